// ===== design/aip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character classes, parser state codes and the transition
// table of the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] value;
  } out_item_t;

  // character classes
  localparam logic [2:0] CLS_ZERO  = 3'd0;
  localparam logic [2:0] CLS_DIGIT = 3'd1;
  localparam logic [2:0] CLS_MINUS = 3'd2;
  localparam logic [2:0] CLS_X     = 3'd3;
  localparam logic [2:0] CLS_LOWER = 3'd4;
  localparam logic [2:0] CLS_UPPER = 3'd5;
  localparam logic [2:0] CLS_SPACE = 3'd6;
  localparam logic [2:0] CLS_OTHER = 3'd7;

  // parser states and transition outcomes
  localparam logic [2:0] ST_LEAD   = 3'd0;
  localparam logic [2:0] ST_ZERO   = 3'd1;
  localparam logic [2:0] ST_DIGITS = 3'd2;
  localparam logic [2:0] ST_MINUS  = 3'd3;
  localparam logic [2:0] ST_HEX0X  = 3'd4;
  localparam logic [2:0] ST_HEX    = 3'd5;
  localparam logic [2:0] ST_ACCEPT = 3'd6;
  localparam logic [2:0] ST_FAIL   = 3'd7;

  // classified character passed from front to back
  typedef struct packed {
    logic       start;
    logic [2:0] cls;
    logic [3:0] digit;
  } cmd_t;

  typedef logic [7:0][2:0] row_t;

  function automatic logic [2:0] next_state(input logic [2:0] st, input logic [2:0] cls);
    row_t row;
    unique case (st)
      ST_ZERO: row = {ST_ACCEPT, ST_ACCEPT, ST_ACCEPT, ST_ACCEPT,
                      ST_HEX0X, ST_ACCEPT, ST_DIGITS, ST_DIGITS};
      ST_DIGITS: row = {ST_ACCEPT, ST_ACCEPT, ST_HEX, ST_HEX,
                        ST_ACCEPT, ST_ACCEPT, ST_DIGITS, ST_DIGITS};
      ST_MINUS: row = {ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL,
                       ST_FAIL, ST_FAIL, ST_DIGITS, ST_ZERO};
      ST_HEX0X: row = {ST_ACCEPT, ST_ACCEPT, ST_HEX, ST_HEX,
                       ST_FAIL, ST_FAIL, ST_HEX, ST_HEX};
      ST_HEX: row = {ST_ACCEPT, ST_ACCEPT, ST_HEX, ST_HEX,
                     ST_ACCEPT, ST_ACCEPT, ST_HEX, ST_HEX};
      default: row = {ST_FAIL, ST_LEAD, ST_HEX, ST_HEX,
                      ST_FAIL, ST_MINUS, ST_DIGITS, ST_ZERO};
    endcase
    return row[cls];
  endfunction

endpackage
`default_nettype wire

// ===== design/aip_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aip_fifo
// Small register FIFO with push/full and pop/empty sides; head shown
// directly on the read port.
// ----------------------------------------------------------------------------
module aip_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rd_data
);
  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/aip_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aip_front
// Character classifier: maps each incoming character to its class and
// digit value and forwards it with the start mark.
// ----------------------------------------------------------------------------
module aip_front (
  input  wire aip_pkg::in_item_t in_item,
  output aip_pkg::cmd_t          cmd
);
  import aip_pkg::*;

  logic [7:0] c;

  assign c = in_item.ch;

  always_comb begin
    cmd.start = in_item.start_req;
    cmd.digit = 4'd0;
    priority if (c == 8'h30) begin
      cmd.cls = CLS_ZERO;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      cmd.cls   = CLS_DIGIT;
      cmd.digit = 4'(c - 8'h30);
    end else if (c == 8'h2d) begin
      cmd.cls = CLS_MINUS;
    end else if (c == 8'h78 || c == 8'h58) begin
      cmd.cls = CLS_X;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      cmd.cls   = CLS_LOWER;
      cmd.digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      cmd.cls   = CLS_UPPER;
      cmd.digit = 4'(c - 8'h37);
    end else if (c == 8'h20) begin
      cmd.cls = CLS_SPACE;
    end else begin
      cmd.cls = CLS_OTHER;
    end
  end

endmodule
`default_nettype wire

// ===== design/aip_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aip_back
// Parser automaton: steps the state, sign and accumulators per character
// and emits one result per string.
// ----------------------------------------------------------------------------
module aip_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire aip_pkg::cmd_t     cmd,
  output logic                   cmd_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output aip_pkg::out_item_t     res_item
);
  import aip_pkg::*;

  logic [2:0]  state_r, state_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] dacc_r, dacc_nxt;
  logic [31:0] hacc_r, hacc_nxt;
  logic        fin_r, fin_nxt;

  logic [2:0]  st_e;
  logic        neg_e;
  logic [31:0] dacc_e, hacc_e;
  logic        fin_e;
  logic [2:0]  nst;
  logic        go;
  logic        ok;
  logic [31:0] v;

  assign go      = cmd_valid && !res_full;
  assign cmd_pop = go;

  always_comb begin
    st_e   = cmd.start ? ST_LEAD : state_r;
    neg_e  = cmd.start ? 1'b0 : neg_r;
    dacc_e = cmd.start ? 32'd0 : dacc_r;
    hacc_e = cmd.start ? 32'd0 : hacc_r;
    fin_e  = cmd.start ? 1'b0 : fin_r;
    nst    = next_state(st_e, cmd.cls);

    ok = 1'b1;
    v  = 32'd0;
    unique case (st_e)
      ST_HEX:    v = hacc_e;
      ST_DIGITS: v = dacc_e;
      ST_ZERO:   v = 32'd0;
      default:   ok = 1'b0;
    endcase

    state_nxt = state_r;
    neg_nxt   = neg_r;
    dacc_nxt  = dacc_r;
    hacc_nxt  = hacc_r;
    fin_nxt   = fin_r;
    res_push  = 1'b0;
    res_item  = '0;

    if (go) begin
      state_nxt = st_e;
      neg_nxt   = neg_e;
      dacc_nxt  = dacc_e;
      hacc_nxt  = hacc_e;
      fin_nxt   = fin_e;
      if (!fin_e) begin
        priority if (nst == ST_FAIL) begin
          fin_nxt  = 1'b1;
          res_push = 1'b1;
        end else if (nst == ST_ACCEPT) begin
          fin_nxt        = 1'b1;
          res_push       = 1'b1;
          res_item.ok    = ok;
          res_item.value = (ok && neg_e) ? 32'(32'd0 - v) : v;
        end else begin
          state_nxt = nst;
          if (nst == ST_DIGITS) begin
            dacc_nxt = (dacc_e << 3) + (dacc_e << 1) + {28'd0, cmd.digit};
            hacc_nxt = {hacc_e[27:0], cmd.digit};
          end else if (nst == ST_MINUS) begin
            neg_nxt = 1'b1;
          end else if (nst == ST_HEX) begin
            hacc_nxt = {hacc_e[27:0], cmd.digit};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LEAD;
      neg_r   <= 1'b0;
      dacc_r  <= '0;
      hacc_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      neg_r   <= neg_nxt;
      dacc_r  <= dacc_nxt;
      hacc_r  <= hacc_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ascii_integer_parser_unit.sv =====
// Path: a result reaches the out_ ports through the command queue, then the
// parser step that writes it into the result queue.
// Throughput: one character per cycle; the parser stalls only while the
// result queue is full, and the input reports full once the command queue fills.
// Reset: synchronous, active low; clears both queues and the parser state.
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit
// ASCII-to-int32 parser: a classifier front, a command queue, and the
// automaton back end feeding a result queue.
// ----------------------------------------------------------------------------
module ascii_integer_parser_unit #(
  parameter int CMD_AW = 2,
  parameter int RES_AW = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire aip_pkg::in_item_t   in_item,
  output logic                     in_full,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output aip_pkg::out_item_t       out_item
);
  import aip_pkg::*;

  cmd_t      fe_cmd;
  cmd_t      be_cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_item;

  aip_front u_front (
    .in_item (in_item),
    .cmd     (fe_cmd)
  );

  aip_fifo #(
    .WIDTH ($bits(cmd_t)),
    .AW    (CMD_AW)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (fe_cmd),
    .full    (in_full),
    .pop     (cmd_pop),
    .empty   (cmd_empty),
    .rd_data (be_cmd)
  );

  aip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (be_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  aip_fifo #(
    .WIDTH ($bits(out_item_t)),
    .AW    (RES_AW)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (out_item)
  );

endmodule
`default_nettype wire
